// ----- src/ufold_pkg.sv -----
package ufold_pkg;

    localparam logic [7:0] CAP_RESET  = 8'd40;
    localparam logic [7:0] BYTE_C3    = 8'hC3;
    localparam logic [7:0] BYTE_CONT  = 8'h80;
    localparam logic [7:0] BYTE_LEAD  = 8'hC0;
    localparam logic [6:0] CH_UNKNOWN = 7'h3F;  // '?'

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'b001,
        MODE_AFTER_C3 = 3'b010,
        MODE_SKIP     = 3'b100
    } t_mode;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [6:0] ch;
    } t_result;

    // Map the second byte of a 0xC3 sequence to a plain letter.
    function automatic logic [6:0] fold_latin1(input logic [7:0] d);
        logic [6:0] r;
        r = CH_UNKNOWN;
        if      (d >= 8'h80 && d <= 8'h85) r = 7'h41;  // A
        else if (d >= 8'hA0 && d <= 8'hA5) r = 7'h61;  // a
        else if (d == 8'h87)               r = 7'h43;  // C
        else if (d == 8'hA7)               r = 7'h63;  // c
        else if (d >= 8'h88 && d <= 8'h8B) r = 7'h45;  // E
        else if (d >= 8'hA8 && d <= 8'hAB) r = 7'h65;  // e
        else if (d >= 8'h8C && d <= 8'h8F) r = 7'h49;  // I
        else if (d >= 8'hAC && d <= 8'hAF) r = 7'h69;  // i
        else if (d == 8'h91)               r = 7'h4E;  // N
        else if (d == 8'hB1)               r = 7'h6E;  // n
        else if (d >= 8'h92 && d <= 8'h96) r = 7'h4F;  // O
        else if (d >= 8'hB2 && d <= 8'hB6) r = 7'h6F;  // o
        else if (d >= 8'h99 && d <= 8'h9C) r = 7'h55;  // U
        else if (d >= 8'hB9 && d <= 8'hBC) r = 7'h75;  // u
        else if (d == 8'h9F)               r = 7'h73;  // s
        return r;
    endfunction

endpackage

// ----- src/ufold_decode.sv -----
module ufold_decode
    import ufold_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_capacity,
    output t_result    o_res
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic       full;

    assign full = ({1'b0, r_count} + 9'd1) >= {1'b0, i_capacity};

    always_comb begin
        o_res   = '0;
        n_mode  = r_mode;
        n_count = r_count;
        if (i_byte == 8'h00) begin
            o_res.emit = 1'b1;
            o_res.last = 1'b1;
            n_mode     = MODE_NORMAL;
            n_count    = 8'd0;
        end else begin
            case (r_mode)
                MODE_AFTER_C3: begin
                    o_res.emit = 1'b1;
                    o_res.ch   = fold_latin1(i_byte);
                    n_mode     = MODE_NORMAL;
                    n_count    = r_count + 8'd1;
                end
                default: begin
                    // drop continuation bytes while skipping
                    if (!(r_mode == MODE_SKIP && i_byte >= BYTE_CONT && i_byte < BYTE_LEAD)) begin
                        n_mode = MODE_NORMAL;
                        if (!full) begin
                            if (i_byte < BYTE_CONT) begin
                                o_res.emit = 1'b1;
                                o_res.ch   = i_byte[6:0];
                                n_count    = r_count + 8'd1;
                            end else if (i_byte == BYTE_C3) begin
                                n_mode = MODE_AFTER_C3;
                            end else begin
                                n_mode = MODE_SKIP;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_count <= 8'd0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_byte == 8'h00 |=> r_count == 8'd0 && r_mode == MODE_NORMAL)
        else $error("terminator did not clear decode state");
    a_c3_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_AFTER_C3 |-> r_count < 8'd254)
        else $error("lead byte accepted without room for its letter");
    a_c3_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_mode == MODE_AFTER_C3 |=> r_mode == MODE_NORMAL)
        else $error("second byte left decoder out of normal mode");
`endif

endmodule

// ----- src/ufold_out_buf.sv -----
module ufold_out_buf
    import ufold_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_res,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_ch,
    output logic       o_last
);

    logic       r_out_valid, r_skid_valid;
    logic [6:0] r_out_ch, r_skid_ch;
    logic       r_out_last, r_skid_last;
    logic       pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_ch    = r_out_ch;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_ch   <= r_skid_ch;
                r_out_last <= r_skid_last;
            end else if (i_push) begin
                r_out_ch   <= i_res.ch;
                r_out_last <= i_res.last;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_ch   <= i_res.ch;
                r_skid_last <= i_res.last;
            end else begin
                r_out_ch   <= i_res.ch;
                r_out_last <= i_res.last;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item ahead of an empty output register");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("item pushed into a full buffer");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid filled while the output drained");
`endif

endmodule

// ----- src/utf8_accent_fold_to_ascii.sv -----
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = in_byte
// m_axis    out        tdata[6:0] = out_byte, tdata[7] = 0; tlast = out_last
// cfg       in         i_cfg_wr_data[7:0] = out_capacity (reset 40)
//
// One byte is taken every cycle while the skid stage of the output buffer is empty.
// The input register feeds the decoder, whose result lands in an output
// register backed by a one-entry skid stage, so a stalled m_axis side holds
// input only once both are full. Reset is synchronous, active low, and
// clears the decode mode, the character count and all valid flags.
module utf8_accent_fold_to_ascii
    import ufold_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_byte, [7] zero
    output logic       m_axis_tlast,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_capacity;
    logic       buf_ready, fire;
    t_result    res;
    logic [6:0] out_ch;

    // advance the input register whenever the result side has room
    assign fire          = r_in_valid && buf_ready;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    ufold_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (r_in_byte),
        .i_capacity (r_capacity),
        .o_res      (res)
    );

    ufold_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && res.emit),
        .i_res   (res),
        .o_ready (buf_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ch    (out_ch),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_ch};

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufold_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASE_ITEMS   = 120;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_CAP,
        CMD_DRAIN,
        CMD_HOLD,
        CMD_IDLE
    } t_cmd;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } t_idle;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] value;
    } t_pending;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_char;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [6:0] out_byte, [7] zero
    logic       m_axis_tlast;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;   // [7:0] out_capacity

    t_pending   byte_q[$];
    t_char      char_q[$];

    // predictor state
    logic [7:0] cap_r     = CAP_RESET;
    t_mode      fold_mode = MODE_NORMAL;
    logic [7:0] emitted_n = 8'd0;

    int         tx_pct    = 0;
    int         rx_pct    = 0;
    int         hold_reqs = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         settle_n  = 0;
    int         bytes_n   = 0;
    int         errors    = 0;
    int         cycles_n  = 0;

    utf8_accent_fold_to_ascii u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Plain letter for the second byte of a 0xC3 pair. Both halves of the
    // 0x80..0xBF range share one letter layout; the upper half is lowercase.
    function automatic logic [6:0] plain_letter(input logic [7:0] d);
        logic [4:0] k;
        logic [6:0] c;
        k = d[4:0];
        c = CH_UNKNOWN;
        if (d[7:6] == 2'b10) begin
            if (k <= 5'd5)                     c = 7'h41;  // A
            else if (k == 5'd7)                c = 7'h43;  // C
            else if (k >= 5'd8 && k <= 5'd11)  c = 7'h45;  // E
            else if (k >= 5'd12 && k <= 5'd15) c = 7'h49;  // I
            else if (k == 5'd17)               c = 7'h4E;  // N
            else if (k >= 5'd18 && k <= 5'd22) c = 7'h4F;  // O
            else if (k >= 5'd25 && k <= 5'd28) c = 7'h55;  // U
            if (c != CH_UNKNOWN && d[5])
                c = c | 7'h20;
            if (d == 8'h9F)
                c = 7'h73;  // sharp s
        end
        return c;
    endfunction

    task automatic emit_char(input logic [6:0] ch, input logic last);
        t_char c;
        c.ch   = ch;
        c.last = last;
        char_q.push_back(c);
    endtask

    task automatic fold_byte(input logic [7:0] b);
        logic full;
        full = ({1'b0, emitted_n} + 9'd1) >= {1'b0, cap_r};
        if (b == 8'h00) begin
            emit_char(7'h00, 1'b1);
            fold_mode = MODE_NORMAL;
            emitted_n = 8'd0;
        end else if (fold_mode == MODE_AFTER_C3) begin
            fold_mode = MODE_NORMAL;
            emit_char(plain_letter(b), 1'b0);
            emitted_n = emitted_n + 8'd1;
        end else if (fold_mode == MODE_SKIP && b >= BYTE_CONT && b < BYTE_LEAD) begin
            // drop continuation byte
        end else begin
            fold_mode = MODE_NORMAL;
            if (!full) begin
                if (b < BYTE_CONT) begin
                    emit_char(b[6:0], 1'b0);
                    emitted_n = emitted_n + 8'd1;
                end else if (b == BYTE_C3) begin
                    fold_mode = MODE_AFTER_C3;
                end else begin
                    fold_mode = MODE_SKIP;
                end
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_pending p;
        p.cmd   = CMD_BYTE;
        p.value = b;
        byte_q.push_back(p);
        bytes_n++;
    endtask

    task automatic push_cmd(input t_cmd cmd, input logic [7:0] value);
        t_pending p;
        p.cmd   = cmd;
        p.value = value;
        byte_q.push_back(p);
    endtask

    // One terminated string of mostly well-formed UTF-8 sequences.
    task automatic add_string(input int units);
        int pick;
        int n;
        repeat (units) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                push_byte(8'($urandom_range(127, 1)));
            end else if (pick < 70) begin
                push_byte(BYTE_C3);
                if (pick < 66)
                    push_byte(8'($urandom_range(191, 128)));
                else
                    push_byte(8'($urandom_range(255, 1)));
            end else if (pick < 93) begin
                n = (pick < 80) ? 1 : (pick < 88) ? 2 : 3;
                if (n == 1)
                    push_byte(8'($urandom_range(223, 194)));
                else if (n == 2)
                    push_byte(8'($urandom_range(239, 224)));
                else
                    push_byte(8'($urandom_range(247, 240)));
                repeat (n) push_byte(8'($urandom_range(191, 128)));
            end else begin
                push_byte(8'($urandom_range(255, 1)));
            end
        end
        // cut a sequence short at the terminator now and then
        if ($urandom_range(9) == 0)
            push_byte(($urandom_range(1) == 0) ? BYTE_C3 : 8'hE2);
        push_byte(8'h00);
    endtask

    // Driver: one item per handshake, config writes only once the block drained.
    always @(posedge i_clk) begin : drive
        logic       nv;
        logic [7:0] nd;
        logic       nwe;
        logic [7:0] nwd;
        logic       go;
        nv  = s_axis_tvalid;
        nd  = s_axis_tdata;
        nwe = 1'b0;
        nwd = i_cfg_wr_data;
        go  = 1'b1;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fold_byte(s_axis_tdata);
                nv = 1'b0;
            end
            while (go && !nv && byte_q.size() != 0) begin
                case (byte_q[0].cmd)
                    CMD_IDLE: begin
                        case (t_idle'(byte_q[0].value[1:0]))
                            IDLE_NONE: begin tx_pct = 0;  rx_pct = 0;  end
                            IDLE_TX:   begin tx_pct = 58; rx_pct = 0;  end
                            IDLE_RX:   begin tx_pct = 0;  rx_pct = 58; end
                            default:   begin tx_pct = 10; rx_pct = 10; end
                        endcase
                        void'(byte_q.pop_front());
                    end
                    CMD_HOLD: begin
                        hold_reqs = hold_reqs + 1;
                        void'(byte_q.pop_front());
                    end
                    CMD_BYTE: begin
                        go = 1'b0;
                        if ($urandom_range(99) >= tx_pct) begin
                            nv = 1'b1;
                            nd = byte_q[0].value;
                            void'(byte_q.pop_front());
                        end
                    end
                    default: begin
                        // hold until every result is out and the pipe has settled
                        go = 1'b0;
                        if (char_q.size() == 0)
                            settle_n++;
                        else
                            settle_n = 0;
                        if (settle_n >= SETTLE_CYCLES) begin
                            settle_n = 0;
                            if (byte_q[0].cmd == CMD_CAP) begin
                                nwe   = 1'b1;
                                nwd   = byte_q[0].value;
                                cap_r = byte_q[0].value;
                            end
                            void'(byte_q.pop_front());
                        end
                    end
                endcase
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        i_cfg_wr_en   <= nwe;
        i_cfg_wr_data <= nwd;
    end

    always @(posedge i_clk) begin : receive
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_pct);
        end
    end

    always @(posedge i_clk) begin : check
        t_char c;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (char_q.size() == 0) begin
                $error("unexpected item: out_byte %02h out_last %0b",
                       m_axis_tdata[6:0], m_axis_tlast);
                errors++;
            end else begin
                c = char_q.pop_front();
                if (m_axis_tdata[6:0] !== c.ch) begin
                    $error("out_byte: expected %02h, got %02h", c.ch, m_axis_tdata[6:0]);
                    errors++;
                end
                if (m_axis_tlast !== c.last) begin
                    $error("out_last: expected %0b, got %0b", c.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[7] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %0b", m_axis_tdata[7]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles_n <= cycles_n + 1;
        if (cycles_n >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : main
        logic [7:0] caps[8];
        logic [7:0] cap;
        int         phase;
        int         start;
        int         units;
        caps = '{8'd40, 8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd17, 8'd128};

        // directed: pass-through extremes, folded letters, drops, lead before terminator
        push_byte(8'h41); push_byte(8'h7F); push_byte(8'h01);
        push_byte(BYTE_C3); push_byte(8'h80);
        push_byte(BYTE_C3); push_byte(8'hBF);
        push_byte(BYTE_C3); push_byte(8'h9F);
        push_byte(BYTE_C3); push_byte(8'h41);
        push_byte(8'hFF); push_byte(8'h85);
        push_byte(8'hC2); push_byte(BYTE_C3); push_byte(8'hA9);
        push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
        push_byte(BYTE_C3); push_byte(8'h00);
        // full buffer, then capacity zero
        push_cmd(CMD_CAP, 8'd4);
        push_byte(8'h41); push_byte(8'h42); push_byte(8'h43); push_byte(8'h44);
        push_byte(BYTE_C3); push_byte(8'hA9); push_byte(8'h00);
        push_cmd(CMD_CAP, 8'd0);
        push_byte(8'h5A); push_byte(8'h00);

        bytes_n = 0;
        phase   = 0;
        while (bytes_n < RANDOM_ITEMS) begin
            cap = (phase < 8) ? caps[phase] : 8'($urandom_range(255, 1));
            push_cmd(CMD_CAP, cap);
            push_cmd(CMD_IDLE, 8'(phase % 4));
            if (phase == 0 || phase == 2)
                push_cmd(CMD_HOLD, 8'd0);
            if (phase == 3) begin
                // long ASCII run to fill the largest buffer
                repeat (270) push_byte(8'($urandom_range(127, 1)));
                push_byte(8'h00);
            end
            start = bytes_n;
            while (bytes_n - start < PHASE_ITEMS) begin
                units = ($urandom_range(3) == 0) ? $urandom_range(80, 40)
                                                 : $urandom_range(30, 0);
                if ($urandom_range(9) == 0) begin
                    repeat (units) push_byte(8'($urandom_range(255, 1)));
                    push_byte(8'h00);
                end else begin
                    add_string(units);
                end
                if (phase == 1 && bytes_n - start >= PHASE_ITEMS / 2)
                    push_cmd(CMD_DRAIN, 8'd0);
            end
            phase++;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_q.size() != 0 || s_axis_tvalid || char_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (char_q.size() != 0) begin
            $error("%0d results never arrived", char_q.size());
            errors++;
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ufold_pkg.sv
src/ufold_decode.sv
src/ufold_out_buf.sv
src/utf8_accent_fold_to_ascii.sv
tb/tb.sv
